@@ hdl/sorted_score_list_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sorted score list
// All checks sample on the rising edge of clk and are off while rst is high.
// ----------------------------------------------------------------------------
`ifndef SORTED_SCORE_LIST_DEFINES_SVH
`define SORTED_SCORE_LIST_DEFINES_SVH

// The condition must hold at every edge.
`define SSL_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// When the first condition holds, the second must hold at the next edge.
`define SSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/ssl_pkg.sv @@
// ----------------------------------------------------------------------------
// ssl_pkg
// Widths, codes and shared types of the sorted score list.
// ----------------------------------------------------------------------------
`default_nettype none

package ssl_pkg;

  localparam int CAPACITY = 16;
  localparam int MAX_OUT  = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int RUN_W    = $clog2(MAX_OUT);

  localparam int FUNC_W   = 3;
  localparam int ID_W     = 16;
  localparam int SCORE_W  = 16;
  localparam int STATUS_W = 2;

  // Request function codes.
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_LIST   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_LOWEST = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SAME   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_BACK   = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd3;

  typedef struct packed {
    logic        [ID_W-1:0]    id;
    logic signed [SCORE_W-1:0] score;
  } entry_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic capture;  // register compare flags against the key
    logic ins;      // open a slot and store the key
    logic del;      // close the slot of the first id match
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ hdl/ssl_if.sv @@
// ----------------------------------------------------------------------------
// ssl_req_if / ssl_res_if
// Valid/ready channels for requests and results of the sorted score list.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssl_req_if;
  import ssl_pkg::*;

  logic                      valid;
  logic                      ready;
  logic        [FUNC_W-1:0]  func;
  logic        [ID_W-1:0]    player_id;
  logic signed [SCORE_W-1:0] score_value;

  modport source (output valid, func, player_id, score_value, input ready);
  modport sink   (input valid, func, player_id, score_value, output ready);
endinterface

interface ssl_res_if;
  import ssl_pkg::*;

  logic                      valid;
  logic                      ready;
  logic        [STATUS_W-1:0] status;
  logic        [ID_W-1:0]     out_id;
  logic signed [SCORE_W-1:0]  out_score;
  logic                       last;

  modport source (output valid, status, out_id, out_score, last, input ready);
  modport sink   (input valid, status, out_id, out_score, last, output ready);
endinterface

`default_nettype wire

@@ hdl/ssl_cell.sv @@
// ----------------------------------------------------------------------------
// ssl_cell
// One slot of the list: holds an entry, compares it to the key and shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module ssl_cell (
  input  wire                clk,
  input  wire                rst,
  input  wire                occ,
  input  ssl_pkg::cell_cmd_t cmd,
  input  ssl_pkg::entry_t    key,
  input  ssl_pkg::entry_t    left_ent,
  input  ssl_pkg::entry_t    right_ent,
  input  wire                left_lt,
  input  wire                left_seen,
  output ssl_pkg::entry_t    ent,
  output logic               lt,
  output logic               seen,
  output logic               first,
  output logic               eq
);
  import ssl_pkg::*;

  logic idm;

  // A match at or before this slot means the slot pulls from the right on delete.
  assign seen  = left_seen | idm;
  assign first = idm & ~left_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      lt  <= 1'b0;
      idm <= 1'b0;
      eq  <= 1'b0;
    end else if (cmd.capture) begin
      lt  <= occ && ($signed(ent.score) < $signed(key.score));
      idm <= occ && (ent.id == key.id);
      eq  <= occ && (ent.score == key.score);
    end
  end

  // Slots below the insert point hold; the insert point takes the key and
  // everything above it moves up by one.
  always_ff @(posedge clk) begin
    if (cmd.ins && !lt) begin
      ent <= left_lt ? key : left_ent;
    end else if (cmd.del && seen) begin
      ent <= right_ent;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ssl_chain.sv @@
// ----------------------------------------------------------------------------
// ssl_chain
// The row of cells, with neighbor links for shifting and the first-match scan.
// ----------------------------------------------------------------------------
`default_nettype none

module ssl_chain (
  input  wire                        clk,
  input  wire                        rst,
  input  wire [ssl_pkg::CNT_W-1:0]   count,
  input  ssl_pkg::cell_cmd_t         cmd,
  input  ssl_pkg::entry_t            key,
  output ssl_pkg::entry_t            ents [ssl_pkg::CAPACITY],
  output logic [ssl_pkg::CAPACITY-1:0] first,
  output logic [ssl_pkg::CAPACITY-1:0] eq,
  output logic                       found
);
  import ssl_pkg::*;

  logic [CAPACITY-1:0] lt;
  logic [CAPACITY-1:0] seen;

  assign found = seen[CAPACITY-1];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   left_lt;
    logic   left_seen;
    logic   occ;

    assign occ = (count > CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_ent  = key;
      assign left_lt   = 1'b1;
      assign left_seen = 1'b0;
    end else begin : g_body
      assign left_ent  = ents[i-1];
      assign left_lt   = lt[i-1];
      assign left_seen = seen[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_ent = ents[i];
    end else begin : g_inner
      assign right_ent = ents[i+1];
    end

    ssl_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .occ       (occ),
      .cmd       (cmd),
      .key       (key),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .left_lt   (left_lt),
      .left_seen (left_seen),
      .ent       (ents[i]),
      .lt        (lt[i]),
      .seen      (seen[i]),
      .first     (first[i]),
      .eq        (eq[i])
    );
  end

endmodule

`default_nettype wire

@@ hdl/sorted_score_list.sv @@
// ----------------------------------------------------------------------------
// sorted_score_list
// Bounded list of (id, score) entries kept in ascending score order.
//
// Requests are taken one at a time. While a request is accepted, all cells
// compare their entry to the request key; in the next cycle the request is
// in execute. Insert, delete, lowest and every status-only answer are
// delivered from execute. List all, same score and backward runs then read
// one cell per cycle through a single read port on the chain, while the
// output register is free: list all and backward give one result per cycle,
// and same score walks one cell per cycle from the lowest entry up to its
// last match. A result waits in an output register, and the run pauses
// while that register is held by the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_score_list_defines.svh"

module sorted_score_list (
  input wire         clk,
  input wire         rst,
  ssl_req_if.sink    req,
  ssl_res_if.source  res
);
  import ssl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RUN
  } state_t;

  // Control state.
  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [IDX_W-1:0]   rd_idx, rd_idx_next;
  logic [RUN_W-1:0]   n_out, n_out_next;

  // Latched request.
  logic [FUNC_W-1:0]         func_r;
  logic [ID_W-1:0]           id_r;
  logic signed [SCORE_W-1:0] score_r;

  // Output register.
  logic                      oval;
  logic [STATUS_W-1:0]       ostatus;
  logic [ID_W-1:0]           oid;
  logic signed [SCORE_W-1:0] oscore;
  logic                      olast;

  // Result being produced in this cycle.
  logic                      emit;
  logic [STATUS_W-1:0]       e_status;
  logic [ID_W-1:0]           e_id;
  logic signed [SCORE_W-1:0] e_score;
  logic                      e_last;

  // Chain connections.
  cell_cmd_t            cmd;
  entry_t               key;
  entry_t               ents [CAPACITY];
  logic [CAPACITY-1:0]  first;
  logic [CAPACITY-1:0]  eq;
  logic                 found;

  logic [IDX_W-1:0]     pos;
  logic [IDX_W-1:0]     rd_addr;
  entry_t               rd_ent;
  logic [CAPACITY-1:0]  above;
  logic                 more_eq;
  logic                 out_free;
  logic                 accept;
  logic                 cap_hit;
  logic                 full_reject;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !oval || res.ready;
  assign cap_hit   = (n_out == RUN_W'(MAX_OUT - 1));

  // An insert that is turned away because every cell is taken.
  assign full_reject = emit && (func_r == FN_INSERT) && (e_status == ST_FULL);

  assign res.valid     = oval;
  assign res.status    = ostatus;
  assign res.out_id    = oid;
  assign res.out_score = oscore;
  assign res.last      = olast;

  // While idle the cells compare against the incoming request; afterwards
  // they see the latched one, which is also the entry an insert stores.
  always_comb begin
    if (state == S_IDLE) begin
      key.id    = req.player_id;
      key.score = req.score_value;
    end else begin
      key.id    = id_r;
      key.score = score_r;
    end
  end

  ssl_chain u_chain (
    .clk   (clk),
    .rst   (rst),
    .count (count),
    .cmd   (cmd),
    .key   (key),
    .ents  (ents),
    .first (first),
    .eq    (eq),
    .found (found)
  );

  // Index of the first id match; the first vector has at most one bit set.
  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        pos = pos | IDX_W'(i);
      end
    end
  end

  // Is there another score match above the cell being read?
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      above[i] = (i > int'(rd_idx));
    end
    more_eq = |(eq & above);
  end

  assign rd_ent = ents[rd_addr];

  always_comb begin
    state_next  = state;
    count_next  = count;
    rd_idx_next = rd_idx;
    n_out_next  = n_out;
    emit        = 1'b0;
    e_status    = ST_OK;
    e_id        = '0;
    e_score     = '0;
    e_last      = 1'b1;
    cmd         = '0;
    cmd.capture = accept;
    rd_addr     = rd_idx;

    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        rd_addr = (func_r == FN_DELETE) ? pos : '0;
        case (func_r)
          FN_INSERT: begin
            if (out_free) begin
              emit       = 1'b1;
              state_next = S_IDLE;
              if (count == CNT_W'(CAPACITY)) begin
                e_status = ST_FULL;
              end else begin
                e_id       = id_r;
                e_score    = score_r;
                cmd.ins    = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
          end

          FN_DELETE: begin
            if (out_free) begin
              emit       = 1'b1;
              state_next = S_IDLE;
              if (found) begin
                e_id       = rd_ent.id;
                e_score    = rd_ent.score;
                cmd.del    = 1'b1;
                count_next = count - CNT_W'(1);
              end else begin
                e_status = ST_MISS;
              end
            end
          end

          FN_LIST: begin
            if (count == '0) begin
              if (out_free) begin
                emit       = 1'b1;
                e_status   = ST_NONE;
                state_next = S_IDLE;
              end
            end else begin
              rd_idx_next = '0;
              n_out_next  = '0;
              state_next  = S_RUN;
            end
          end

          FN_LOWEST: begin
            if (out_free) begin
              emit       = 1'b1;
              state_next = S_IDLE;
              if (count == '0) begin
                e_status = ST_NONE;
              end else begin
                e_id    = rd_ent.id;
                e_score = rd_ent.score;
              end
            end
          end

          FN_SAME: begin
            if (eq == '0) begin
              if (out_free) begin
                emit       = 1'b1;
                e_status   = ST_NONE;
                state_next = S_IDLE;
              end
            end else begin
              rd_idx_next = '0;
              n_out_next  = '0;
              state_next  = S_RUN;
            end
          end

          FN_BACK: begin
            if (!found || pos == '0) begin
              // Unknown id, or the id already sits at the lowest place.
              if (out_free) begin
                emit       = 1'b1;
                e_status   = found ? ST_NONE : ST_MISS;
                state_next = S_IDLE;
              end
            end else begin
              rd_idx_next = pos - IDX_W'(1);
              n_out_next  = '0;
              state_next  = S_RUN;
            end
          end

          default: begin
            // Unused codes give no result.
            state_next = S_IDLE;
          end
        endcase
      end

      S_RUN: begin
        case (func_r)
          FN_SAME: begin
            if (!eq[rd_idx]) begin
              rd_idx_next = rd_idx + IDX_W'(1);
            end else if (out_free) begin
              emit   = 1'b1;
              e_last = !more_eq || cap_hit;
            end
          end

          FN_BACK: begin
            if (out_free) begin
              emit   = 1'b1;
              e_last = (rd_idx == '0) || cap_hit;
            end
          end

          default: begin
            if (out_free) begin
              emit   = 1'b1;
              e_last = (CNT_W'(rd_idx) == count - CNT_W'(1)) || cap_hit;
            end
          end
        endcase

        if (emit) begin
          e_id    = rd_ent.id;
          e_score = rd_ent.score;
          if (e_last) begin
            state_next = S_IDLE;
          end else begin
            n_out_next  = n_out + RUN_W'(1);
            rd_idx_next = (func_r == FN_BACK) ? rd_idx - IDX_W'(1)
                                              : rd_idx + IDX_W'(1);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      rd_idx <= '0;
      n_out  <= '0;
      oval   <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      rd_idx <= rd_idx_next;
      n_out  <= n_out_next;

      if (emit) begin
        oval <= 1'b1;
      end else if (res.ready) begin
        oval <= 1'b0;
      end
    end

    if (accept) begin
      func_r  <= req.func;
      id_r    <= req.player_id;
      score_r <= req.score_value;
    end

    if (emit) begin
      ostatus <= e_status;
      oid     <= e_id;
      oscore  <= e_score;
      olast   <= e_last;
    end
  end

  // The list never holds more entries than it has cells.
  `SSL_ASSERT(a_count_bound, count <= CNT_W'(CAPACITY), "entry count above capacity")
  // A new result is only produced when the output register can take it.
  `SSL_ASSERT(a_emit_free, !emit || !oval || res.ready, "pending result overwritten")
  // Every status-only result closes its run.
  `SSL_ASSERT(a_status_last, !oval || ostatus == ST_OK || olast, "status result without last")
  // An insert into a full list must leave the count alone.
  `SSL_ASSERT_NEXT(a_full_stable, full_reject, $stable(count), "full insert changed count")

endmodule

`default_nettype wire
